### hw/rtl/gna_pkg.sv
package gna_pkg;

  localparam int PIXEL_BITS   = 16;
  localparam int UNIFORM_BITS = 24;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE_VARIANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_MEAN     = 2'd1;

  localparam logic [CFG_W-1:0] VARIANCE_RESET = 16'd100;
  localparam logic [CFG_W-1:0] MEAN_RESET     = 16'd0;

  // Fixed point: Q30 throughout the log and trig datapaths.
  localparam int FRAC_BITS    = 30;
  localparam int LOG_STEPS    = 30;
  localparam int HORNER_STEPS = 6;

  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

  localparam int EXP_W    = $clog2(UNIFORM_BITS + 1);
  localparam int NL_W     = EXP_W + FRAC_BITS;
  localparam int ARG_W    = CFG_W + NL_W;
  localparam int SQ_STEPS = (ARG_W + 5) / 2;
  localparam int RAD_W    = 2 * SQ_STEPS;
  localparam int MAG_W    = SQ_STEPS + 1;
  localparam int WIDE_IN  = (PIXEL_BITS > CFG_W) ? PIXEL_BITS : CFG_W;
  localparam int TOT_W    = (WIDE_IN + 18 > MAG_W + 2) ? WIDE_IN + 18 : MAG_W + 2;

  // Horner divisors for the cosine and sine series, innermost term first,
  // with floor(2^30 / d) as the reciprocal.
  localparam logic [7:0]  COS_DIV   [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [7:0]  SIN_DIV   [HORNER_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [29:0] COS_RECIP [HORNER_STEPS] = '{30'd8134407, 30'd11930464, 30'd19173961,
                                                       30'd35791394, 30'd89478485, 30'd536870912};
  localparam logic [29:0] SIN_RECIP [HORNER_STEPS] = '{30'd6882960, 30'd9761289, 30'd14913080,
                                                       30'd25565281, 30'd53687091, 30'd178956970};

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] pixel_in;
    logic [UNIFORM_BITS-1:0]      uniform_radius;
    logic [UNIFORM_BITS-1:0]      uniform_angle;
  } in_word_t;

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] pixel_out;
    logic                         clipped;
  } out_word_t;

endpackage

### hw/rtl/gaussian_noise_adder_core.sv
// Gaussian noise adder: pixel plus Box-Muller noise, rounded and saturated.
// Throughput: one word per clock; the whole pipeline, whose depth is set by the
// thirty log cells and the square root cells, advances together whenever the
// output is not stalled. Reset clears the stage valid bits and loads the
// registers with variance 100 and mean 0; the datapath registers are not reset.
module gaussian_noise_adder_core import gna_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // Pipeline depths, counted in register stages after acceptance.
  localparam int D_RADI = LOG_STEPS + 5;
  localparam int D_ROOT = D_RADI + SQ_STEPS;
  localparam int D_C    = 3 * HORNER_STEPS + 4;
  localparam int NST    = D_ROOT + 2;

  logic [NST:1] vld_q;
  logic         en;

  logic [CFG_W-1:0]        var_q;
  logic signed [CFG_W-1:0] mean_q;

  // The whole chain moves as one; a bubble simply travels with a cleared valid bit.
  assign en         = ~(vld_q[NST] & out_stall_i);
  assign in_stall_o = ~en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      var_q  <= VARIANCE_RESET;
      mean_q <= MEAN_RESET;
    end else begin
      if (en) begin
        vld_q <= {vld_q[NST-1:1], in_valid_i};
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_NOISE_VARIANCE) begin
          var_q <= cfg_wdata_i;
        end else if (cfg_idx_i == REG_NOISE_MEAN) begin
          mean_q <= cfg_wdata_i;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: normalise 1-u1 to a Q30 mantissa in [1,2) and fold the phase into
  // the first octant, noting whether the sine or the cosine series is needed.
  // ---------------------------------------------------------------------------
  logic [UNIFORM_BITS:0]    xr;
  logic [EXP_W-1:0]         e_c;
  logic [UNIFORM_BITS+30:0] norm;
  logic [31:0]              t0;
  logic [32:0]              t1;
  logic [30:0]              t2, tf_c;
  logic                     neg_c, sel_c;

  always_comb begin
    xr   = {1'b1, {UNIFORM_BITS{1'b0}}} - {1'b0, in_word_i.uniform_radius};
    e_c  = '0;
    for (int i = 0; i <= UNIFORM_BITS; i++) begin
      if (xr[i]) begin
        e_c = EXP_W'(i);
      end
    end
    norm = {xr, 30'b0} >> e_c;

    t0 = 32'(in_word_i.uniform_angle) << (32 - UNIFORM_BITS);
    if (t0 > 32'h8000_0000) begin
      t1 = 33'h1_0000_0000 - {1'b0, t0};
    end else begin
      t1 = {1'b0, t0};
    end
    // cos(2*pi*u2 - pi) is minus cos(2*pi*u2); folding past a quarter turn flips it back.
    if (t1 > 33'h0_4000_0000) begin
      t2    = 31'(33'h0_8000_0000 - t1);
      neg_c = 1'b0;
    end else begin
      t2    = t1[30:0];
      neg_c = 1'b1;
    end
    sel_c = (t2 > 31'h2000_0000);
    tf_c  = sel_c ? (31'h4000_0000 - t2) : t2;
  end

  logic [30:0]                  s1_m_q, s1_tf_q;
  logic [EXP_W-1:0]             s1_e_q;
  logic                         s1_sel_q, s1_neg_q;
  logic signed [PIXEL_BITS-1:0] s1_pix_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_m_q   <= norm[30:0];
      s1_e_q   <= e_c;
      s1_tf_q  <= tf_c;
      s1_sel_q <= sel_c;
      s1_neg_q <= neg_c;
      s1_pix_q <= in_word_i.pixel_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Radius path: log cells, then variance scaling, then square root cells.
  // ---------------------------------------------------------------------------
  logic [30:0]      lm [LOG_STEPS+1];
  logic [29:0]      lf [LOG_STEPS+1];
  logic [EXP_W-1:0] le [LOG_STEPS+1];

  assign lm[0] = s1_m_q;
  assign lf[0] = '0;
  assign le[0] = s1_e_q;

  for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
    gna_log_cell #(.IDX(k + 1)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .m_i    (lm[k]),
      .frac_i (lf[k]),
      .e_i    (le[k]),
      .m_o    (lm[k+1]),
      .frac_o (lf[k+1]),
      .e_o    (le[k+1])
    );
  end

  logic [NL_W-1:0]    nl_q;
  logic [ARG_W-1:0]   arg_q;
  logic [ARG_W:0]     hi_q;
  logic [60:0]        lo_full;
  logic [30:0]        lo_q;
  logic [ARG_W+1:0]   rad_sum;
  logic [RAD_W-1:0]   radi_q;

  assign lo_full = arg_q[29:0] * TWO_LN2_Q30;
  assign rad_sum = (ARG_W+2)'(hi_q) + (ARG_W+2)'(lo_q);

  // -log2(1-u1) = (bits - exponent) - fraction, then 2*ln2*variance times that.
  always_ff @(posedge clk_i) begin
    if (en) begin
      nl_q   <= ((NL_W'(UNIFORM_BITS) - NL_W'(le[LOG_STEPS])) << FRAC_BITS)
                - NL_W'(lf[LOG_STEPS]);
      arg_q  <= var_q * nl_q;
      hi_q   <= arg_q[ARG_W-1:FRAC_BITS] * TWO_LN2_Q30;
      lo_q   <= lo_full[60:30];
      radi_q <= RAD_W'({rad_sum, 2'b00});
    end
  end

  logic [RAD_W-1:0] sv [SQ_STEPS+1];
  logic [RAD_W-1:0] sr [SQ_STEPS+1];

  assign sv[0] = radi_q;
  assign sr[0] = '0;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    gna_sqrt_cell #(.K(SQ_STEPS - 1 - k)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .v_i   (sv[k]),
      .res_i (sr[k]),
      .v_o   (sv[k+1]),
      .res_o (sr[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Phase path: angle in Q30 radians, x squared, Horner cells, then sine finish.
  // ---------------------------------------------------------------------------
  logic [62:0] xprod;
  logic [29:0] s2_x_q, s3_x_q, s3_x2_q;
  logic        s2_sel_q, s3_sel_q;
  logic [59:0] x2prod;

  assign xprod  = s1_tf_q * PI_Q30;
  assign x2prod = s2_x_q * s2_x_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_x_q   <= xprod[60:31];
      s2_sel_q <= s1_sel_q;
      s3_x_q   <= s2_x_q;
      s3_x2_q  <= x2prod[59:30];
      s3_sel_q <= s2_sel_q;
    end
  end

  logic [29:0] hx2 [HORNER_STEPS+1];
  logic [29:0] hx  [HORNER_STEPS+1];
  logic [30:0] hv  [HORNER_STEPS+1];
  logic        hs  [HORNER_STEPS+1];

  assign hx2[0] = s3_x2_q;
  assign hx[0]  = s3_x_q;
  assign hv[0]  = Q30_ONE;
  assign hs[0]  = s3_sel_q;

  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
    gna_horner_cell #(.IDX(k)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x2_i  (hx2[k]),
      .x_i   (hx[k]),
      .v_i   (hv[k]),
      .sel_i (hs[k]),
      .x2_o  (hx2[k+1]),
      .x_o   (hx[k+1]),
      .v_o   (hv[k+1]),
      .sel_o (hs[k+1])
    );
  end

  logic [60:0] sprod;
  logic [30:0] c_q, c_dly;

  assign sprod = hx[HORNER_STEPS] * hv[HORNER_STEPS];

  // The sine series is finished by one more multiply by x.
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q <= hs[HORNER_STEPS] ? sprod[60:30] : hv[HORNER_STEPS];
    end
  end

  // Line the phase result up with the root, and the pixel and sign with the magnitude.
  gna_delay #(.W(31), .N(D_ROOT - D_C)) u_c_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (c_q),
    .q_o   (c_dly)
  );

  logic [PIXEL_BITS:0] side_dly;

  gna_delay #(.W(PIXEL_BITS + 1), .N(D_ROOT)) u_side_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({s1_neg_q, s1_pix_q}),
    .q_o   (side_dly)
  );

  // ---------------------------------------------------------------------------
  // Magnitude, rounded half up, then the sum plus one half, floored and saturated.
  // ---------------------------------------------------------------------------
  logic [SQ_STEPS+30:0] mprod;
  logic [MAG_W-1:0]     mag_q;

  assign mprod = (SQ_STEPS + 31)'(sr[SQ_STEPS][SQ_STEPS-1:0]) * (SQ_STEPS + 31)'(c_dly)
                 + (SQ_STEPS + 31)'(32'h2000_0000);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= mprod[SQ_STEPS+30:30];
    end
  end

  logic signed [TOT_W-1:0]    base, total, magx;
  logic signed [TOT_W-17:0]   res, lo_lim, hi_lim;
  logic signed [PIXEL_BITS-1:0] pix_out_d, pix_out_q;
  logic                       clip_d, clip_q;

  always_comb begin
    base   = ((TOT_W'($signed(side_dly[PIXEL_BITS-1:0])) + TOT_W'(mean_q)) <<< 16)
             + TOT_W'(32'sd32768);
    magx   = $signed(TOT_W'(mag_q));
    total  = side_dly[PIXEL_BITS] ? (base - magx) : (base + magx);
    res    = total[TOT_W-1:16];
    lo_lim = -((TOT_W-16)'(1) <<< (PIXEL_BITS - 1));
    hi_lim = ((TOT_W-16)'(1) <<< (PIXEL_BITS - 1)) - (TOT_W-16)'(1);
    clip_d = 1'b1;
    if (res < lo_lim) begin
      pix_out_d = lo_lim[PIXEL_BITS-1:0];
    end else if (res > hi_lim) begin
      pix_out_d = hi_lim[PIXEL_BITS-1:0];
    end else begin
      pix_out_d = res[PIXEL_BITS-1:0];
      clip_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_out_q <= pix_out_d;
      clip_q    <= clip_d;
    end
  end

  assign out_valid_o          = vld_q[NST];
  assign out_word_o.pixel_out = pix_out_q;
  assign out_word_o.clipped   = clip_q;

endmodule

### hw/rtl/gna_delay.sv
module gna_delay import gna_pkg::*; #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[N-1];

endmodule

### hw/rtl/gna_log_cell.sv
module gna_log_cell import gna_pkg::*; #(
  parameter int IDX = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [30:0]      m_i,
  input  logic [29:0]      frac_i,
  input  logic [EXP_W-1:0] e_i,
  output logic [30:0]      m_o,
  output logic [29:0]      frac_o,
  output logic [EXP_W-1:0] e_o
);

  logic [61:0]      sq;
  logic [31:0]      s;
  logic [30:0]      m_d, m_q;
  logic [29:0]      frac_d, frac_q;
  logic [EXP_W-1:0] e_q;

  // One bit of the fraction per squaring of the normalised mantissa.
  always_comb begin
    sq     = m_i * m_i;
    s      = sq[61:30];
    frac_d = frac_i;
    if (s[31]) begin
      m_d                    = s[31:1];
      frac_d[LOG_STEPS-IDX]  = 1'b1;
    end else begin
      m_d = s[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= m_d;
      frac_q <= frac_d;
      e_q    <= e_i;
    end
  end

  assign m_o    = m_q;
  assign frac_o = frac_q;
  assign e_o    = e_q;

endmodule

### hw/rtl/gna_sqrt_cell.sv
module gna_sqrt_cell import gna_pkg::*; #(
  parameter int K = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [RAD_W-1:0] v_i,
  input  logic [RAD_W-1:0] res_i,
  output logic [RAD_W-1:0] v_o,
  output logic [RAD_W-1:0] res_o
);

  logic [RAD_W-1:0] bit_w;
  logic [RAD_W:0]   trial;
  logic [RAD_W-1:0] v_d, v_q, res_d, res_q;

  // One restoring step of the digit-by-digit square root.
  always_comb begin
    bit_w = RAD_W'(1) << (2 * K);
    trial = {1'b0, res_i} + {1'b0, bit_w};
    if ({1'b0, v_i} >= trial) begin
      v_d   = v_i - trial[RAD_W-1:0];
      res_d = (res_i >> 1) + bit_w;
    end else begin
      v_d   = v_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q   <= v_d;
      res_q <= res_d;
    end
  end

  assign v_o   = v_q;
  assign res_o = res_q;

endmodule

### hw/rtl/gna_horner_cell.sv
module gna_horner_cell import gna_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [29:0] x2_i,
  input  logic [29:0] x_i,
  input  logic [30:0] v_i,
  input  logic        sel_i,
  output logic [29:0] x2_o,
  output logic [29:0] x_o,
  output logic [30:0] v_o,
  output logic        sel_o
);

  logic [60:0] pa_full;
  logic [29:0] pa_q, pb_q;
  logic [29:0] x2a_q, x2b_q, x2c_q, xa_q, xb_q, xc_q;
  logic        sela_q, selb_q, selc_q;
  logic [29:0] recip;
  logic [59:0] qb_full;
  logic [29:0] q0_q;
  logic [7:0]  dv;
  logic [37:0] prod_c, rem_c;
  logic [29:0] q_c;
  logic [30:0] v_q;

  // Stage a: product with x^2. Stage b: reciprocal multiply.
  // Stage c: correct the quotient by at most one and subtract from one.
  always_comb begin
    pa_full = x2_i * v_i;
    recip   = sela_q ? SIN_RECIP[IDX] : COS_RECIP[IDX];
    qb_full = pa_q * recip;
    dv      = selb_q ? SIN_DIV[IDX] : COS_DIV[IDX];
    prod_c  = q0_q * dv;
    rem_c   = 38'(pb_q) - prod_c;
    q_c     = (rem_c >= 38'(dv)) ? q0_q + 30'd1 : q0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q   <= pa_full[59:30];
      x2a_q  <= x2_i;
      xa_q   <= x_i;
      sela_q <= sel_i;
      q0_q   <= qb_full[59:30];
      pb_q   <= pa_q;
      x2b_q  <= x2a_q;
      xb_q   <= xa_q;
      selb_q <= sela_q;
      v_q    <= Q30_ONE - 31'(q_c);
      x2c_q  <= x2b_q;
      xc_q   <= xb_q;
      selc_q <= selb_q;
    end
  end

  assign x2_o  = x2c_q;
  assign x_o   = xc_q;
  assign v_o   = v_q;
  assign sel_o = selc_q;

endmodule

### dv/gaussian_noise_adder_core_tb.sv
module gaussian_noise_adder_core_tb;
  import gna_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The quiet period after the last result and the long receiver hold-off are
  // both sized well beyond the depth of the pipeline.
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_WORDS = 400;

  // Scoreboard: holds its own copy of the two noise registers, predicts the
  // result of every accepted word and compares results in order of arrival.
  class noise_scoreboard;
    logic [15:0]        variance;
    logic signed [15:0] mean;
    out_word_t          pending[$];
    int unsigned        errors;

    function new();
      variance = VARIANCE_RESET;
      mean     = MEAN_RESET;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_NOISE_VARIANCE) begin
        variance = data;
      end else if (idx == REG_NOISE_MEAN) begin
        mean = data;
      end
    endfunction

    // -log2 of (1 - r/2^24) in Q30, one fraction bit per squaring step.
    function automatic logic [63:0] neg_log2(logic [UNIFORM_BITS-1:0] r);
      logic [63:0] x;
      logic [63:0] m;
      logic [63:0] frac;
      int          e;
      x    = (64'd1 << UNIFORM_BITS) - r;
      e    = 0;
      frac = 0;
      while ((x >> e) > 1) e++;
      m = x << (30 - e);
      for (int i = 1; i <= 30; i++) begin
        m = (m * m) >> 30;
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          frac |= 64'd1 << (30 - i);
        end
      end
      return (64'(UNIFORM_BITS - e) << 30) - frac;
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Truncating Horner evaluation of the cosine or sine series in Q30.
    function automatic logic [63:0] series(logic [63:0] x, bit use_sine);
      logic [63:0] x2;
      logic [63:0] v;
      x2 = (x * x) >> 30;
      v  = 64'd1 << 30;
      for (int i = 0; i < HORNER_STEPS; i++) begin
        v = (64'd1 << 30) - ((x2 * v) >> 30) / (use_sine ? SIN_DIV[i] : COS_DIV[i]);
      end
      return use_sine ? (x * v) >> 30 : v;
    endfunction

    function automatic out_word_t noisy_pixel(in_word_t w);
      logic [63:0]    arg;
      logic [63:0]    rad;
      logic [63:0]    root;
      logic [63:0]    t;
      logic [63:0]    c;
      logic [63:0]    mag;
      logic [63:0]    q_one;
      logic signed [63:0] total;
      logic signed [63:0] res;
      bit             negative;
      out_word_t      o;
      q_one = 64'd1 << 30;
      arg  = 64'(variance) * neg_log2(w.uniform_radius);
      rad  = (arg >> 30) * 64'(TWO_LN2_Q30) + (((arg & (q_one - 1)) * 64'(TWO_LN2_Q30)) >> 30);
      root = int_root(rad << 2);
      // Fold the phase into the first octant; cos(2*pi*u - pi) starts negative.
      negative = 1'b1;
      t = 64'(w.uniform_angle) << (32 - UNIFORM_BITS);
      if (t > (64'd1 << 31)) t = (64'd1 << 32) - t;
      if (t > (64'd1 << 30)) begin
        t = (64'd1 << 31) - t;
        negative = !negative;
      end
      if (t > (64'd1 << 29)) begin
        c = series((((64'd1 << 30) - t) * 64'(PI_Q30)) >> 31, 1'b1);
      end else begin
        c = series((t * 64'(PI_Q30)) >> 31, 1'b0);
      end
      mag   = (root * c + (64'd1 << 29)) >> 30;
      total = 64'(w.pixel_in) * 65536 + 64'(mean) * 65536 + 32768;
      total = negative ? total - $signed(mag) : total + $signed(mag);
      res   = total >>> 16;
      o.clipped = 1'b0;
      if (res < -32768) begin
        res = -64'sd32768;
        o.clipped = 1'b1;
      end else if (res > 32767) begin
        res = 64'sd32767;
        o.clipped = 1'b1;
      end
      o.pixel_out = res[15:0];
      return o;
    endfunction

    function void note_input(in_word_t w);
      pending.push_back(noisy_pixel(w));
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $error("unexpected result word pixel_out=%0d", got.pixel_out);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.pixel_out !== exp_w.pixel_out) begin
        $error("pixel_out: expected %0d, actual %0d", exp_w.pixel_out, got.pixel_out);
        errors++;
      end
      if (got.clipped !== exp_w.clipped) begin
        $error("clipped: expected %0b, actual %0b", exp_w.clipped, got.clipped);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_word;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  noise_scoreboard sb;
  int unsigned     cycle_count;
  bit              hold_off_req;
  bit              stall_random;

  gaussian_noise_adder_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results are sampled at the rising edge, when the handshake completes.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_word);
    end
  end

  // Watchdog on the total number of cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[gaussian_noise_adder_core] ERROR");
      $finish;
    end
  end

  // The receiver stalls on its own pattern: calm stretches, random stretches,
  // and when asked, one long hold-off counted here so that the pipe fills up.
  initial begin
    int unsigned mode_len;
    int unsigned mode;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      mode     = $urandom_range(0, 3);
      mode_len = $urandom_range(10, 80);
      for (int unsigned i = 0; i < mode_len; i++) begin
        @(negedge clk);
        if (hold_off_req) begin
          for (int unsigned k = 0; k < 3 * DRAIN_CYCLES; k++) begin
            out_stall <= 1'b1;
            @(negedge clk);
          end
          hold_off_req = 1'b0;
        end
        if (!stall_random || mode == 0) begin
          out_stall <= 1'b0;
        end else if (mode == 1) begin
          out_stall <= ($urandom_range(0, 9) < 8);
        end else begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
      end
    end
  end

  // Offers one word and holds it until it is accepted.
  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(w);
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
  endtask

  // Waits for every expected word, then lets the pipeline settle.
  task automatic drain();
    go_idle();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // The write enable is dropped for one cycle between writes.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic in_word_t rand_word();
    in_word_t w;
    w.pixel_in       = 16'($urandom());
    w.uniform_radius = 24'($urandom());
    w.uniform_angle  = 24'($urandom());
    case ($urandom_range(0, 5))
      0: w.pixel_in = $urandom_range(0, 1) ? 16'(16'sh7fff - $urandom_range(0, 40))
                                            : 16'(16'sh8000 + $urandom_range(0, 40));
      1: w.uniform_radius = $urandom_range(0, 1) ? 24'(24'hffffff - $urandom_range(0, 255))
                                                  : 24'($urandom_range(0, 255));
      2: w.uniform_angle = 24'((24'h200000 * $urandom_range(0, 7)) + $urandom_range(0, 3) - 1);
      default: ;
    endcase
    return w;
  endfunction

  // Random words in bursts, with gaps between some of them.
  task automatic random_phase(int unsigned count);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      for (int unsigned i = 0; i < burst && sent < count; i++) begin
        send_word(rand_word());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        go_idle();
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  endtask

  initial begin
    in_word_t dw;
    logic [CFG_W-1:0] variances[4];
    logic [CFG_W-1:0] means[4];
    sb           = new();
    cycle_count  = 0;
    hold_off_req = 1'b0;
    stall_random = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_NOISE_VARIANCE;
    cfg_wdata    = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed words at the reset settings: zero radius, field extremes,
    // phase at each octant boundary, and a large radius draw.
    dw = '{pixel_in: 16'sd0, uniform_radius: 24'd0, uniform_angle: 24'd0};
    send_word(dw);
    dw = '{pixel_in: 16'sh7fff, uniform_radius: 24'hffffff, uniform_angle: 24'd0};
    send_word(dw);
    dw = '{pixel_in: 16'sh8000, uniform_radius: 24'hffffff, uniform_angle: 24'h800000};
    send_word(dw);
    for (int k = 0; k < 8; k++) begin
      dw = '{pixel_in: 16'sd100, uniform_radius: 24'h800000,
             uniform_angle: 24'(k * 24'h200000)};
      send_word(dw);
    end
    dw = '{pixel_in: 16'sh5555, uniform_radius: 24'haaaaaa, uniform_angle: 24'h555555};
    send_word(dw);
    dw = '{pixel_in: 16'shaaaa, uniform_radius: 24'h555555, uniform_angle: 24'haaaaaa};
    send_word(dw);
    dw = '{pixel_in: 16'sh7ffe, uniform_radius: 24'hfffffe, uniform_angle: 24'hffffff};
    send_word(dw);
    drain();

    // Zero variance gives the pixel plus the mean, with saturation at the top and the bottom.
    write_reg(REG_NOISE_VARIANCE, 16'd0);
    write_reg(REG_NOISE_MEAN, 16'sh7fff);
    dw = '{pixel_in: 16'sh7fff, uniform_radius: 24'hffffff, uniform_angle: 24'h123456};
    send_word(dw);
    dw = '{pixel_in: 16'sh8000, uniform_radius: 24'h0, uniform_angle: 24'h0};
    send_word(dw);
    drain();
    write_reg(REG_NOISE_MEAN, 16'sh8000);
    send_word(dw);
    dw = '{pixel_in: 16'sh7fff, uniform_radius: 24'h0, uniform_angle: 24'h0};
    send_word(dw);
    drain();

    // Random phases over several register settings, extremes included.
    stall_random = 1'b1;
    variances = '{16'hffff, 16'd1, 16'd100, 16'd5000};
    means     = '{16'h0000, 16'h7fff, 16'h8000, 16'hffd0};
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_NOISE_VARIANCE, variances[p]);
      write_reg(REG_NOISE_MEAN, means[p]);
      if (p == 1) begin
        // Long hold-off at the output while words keep coming.
        hold_off_req = 1'b1;
      end
      random_phase(RANDOM_WORDS / 4);
      if (p == 2) begin
        // The sender pauses until every expected word has come back.
        go_idle();
        while (sb.pending.size() != 0) @(negedge clk);
      end
      if (p != 3) begin
        drain();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("[gaussian_noise_adder_core] OK");
    end else begin
      $display("[gaussian_noise_adder_core] ERROR");
    end
    $finish;
  end

endmodule
